FILE: hdl/rigid_transform_adjoint_unit_core_defines.svh
// Assertion macros shared by the rigid transform unit.
// Each use expands to a labeled concurrent assertion clocked on clk and
// disabled while rst_n is low. Under SYNTH the uses expand to nothing.
`ifndef RIGID_TRANSFORM_ADJOINT_UNIT_CORE_DEFINES_SVH
`define RIGID_TRANSFORM_ADJOINT_UNIT_CORE_DEFINES_SVH

`ifndef SYNTH
// ante |-> cons in the same cycle
`define RTAU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtau: same-cycle check failed");
// ante |=> cons in the next cycle
`define RTAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtau: next-cycle check failed");
`else
`define RTAU_ASSERT_IMPL(label, ante, cons)
`define RTAU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hdl/rtau_pkg.sv
package rtau_pkg;

    // Field and register widths
    localparam int CfgW     = 48;
    localparam int CfgIdxW  = 3;
    localparam int WordW    = 32;
    localparam int CoefW    = 16;

    // Fixed-point shifts: Q1.14 rotation, Q16.16 cross product
    localparam int RotShift = 14;
    localparam int CrsShift = 16;

    // Internal widths
    localparam int RotProdW = CoefW + WordW;
    localparam int RotTermW = RotProdW - RotShift;
    localparam int RotSumW  = RotTermW + 2;      // three terms plus translation
    localparam int CrsProdW = 2 * WordW;
    localparam int CrsTermW = CrsProdW - CrsShift;
    localparam int CrsDiffW = CrsTermW + 1;
    localparam int WideW    = CrsDiffW + 1;      // widest pre-saturation sum

    // Pipeline depths of the two halves
    localparam int FrontDepth = 4;
    localparam int BackDepth  = 3;

    // Reset pose: identity rotation
    localparam logic [CfgW-1:0] RotRow0Rst = 48'h0000_0000_4000;
    localparam logic [CfgW-1:0] RotRow1Rst = 48'h0000_4000_0000;
    localparam logic [CfgW-1:0] RotRow2Rst = 48'h4000_0000_0000;

    typedef logic signed [CoefW-1:0]    coef_t;
    typedef logic signed [WordW-1:0]    word_t;
    typedef logic signed [RotProdW-1:0] rprod_t;
    typedef logic signed [RotSumW-1:0]  rsum_t;
    typedef logic signed [CrsProdW-1:0] cprod_t;
    typedef logic signed [CrsDiffW-1:0] cdiff_t;
    typedef logic signed [WideW-1:0]    wide_t;

    typedef enum logic [1:0] {
        FUNC_POINT     = 2'd0,
        FUNC_POINT_INV = 2'd1,
        FUNC_ADJ       = 2'd2,
        FUNC_ADJ_T     = 2'd3
    } func_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ROT_ROW0 = 3'd0,
        REG_ROT_ROW1 = 3'd1,
        REG_ROT_ROW2 = 3'd2,
        REG_TRANS_X  = 3'd3,
        REG_TRANS_Y  = 3'd4,
        REG_TRANS_Z  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        func_t func;
        word_t in_v0;
        word_t in_v1;
        word_t in_v2;
        word_t in_v3;
        word_t in_v4;
        word_t in_v5;
    } req_t;

    typedef struct packed {
        word_t out_v0;
        word_t out_v1;
        word_t out_v2;
        word_t out_v3;
        word_t out_v4;
        word_t out_v5;
    } rsp_t;

    // Pose as used by the datapath: rot[row][col], trans[axis]
    typedef struct packed {
        coef_t [2:0][2:0] rot;
        word_t [2:0]      trans;
    } pose_t;

    // Hand-off from the front half to the back half
    typedef struct packed {
        func_t        func;
        word_t [2:0]  ra;   // first rotation, saturated
        word_t [2:0]  bv;   // x_bot - t x x_top, saturated
        rsum_t [2:0]  sb;   // R*x_top, unsaturated
    } mid_t;

    // Clamp to the signed 32-bit range
    function automatic word_t sat_word(input wide_t v);
        if ((&v[WideW-1:WordW-1]) || !(|v[WideW-1:WordW-1]))
            return v[WordW-1:0];
        else if (v[WideW-1])
            return {1'b1, {(WordW-1){1'b0}}};
        else
            return {1'b0, {(WordW-1){1'b1}}};
    endfunction

    function automatic rprod_t rot_mul(input coef_t c, input word_t x);
        return RotProdW'(c) * RotProdW'(x);
    endfunction

    function automatic cprod_t crs_mul(input word_t a, input word_t b);
        return CrsProdW'(a) * CrsProdW'(b);
    endfunction

    // Floor shift by dropping low bits, then sign-extend to sum width
    function automatic rsum_t rot_term(input rprod_t p);
        return RotSumW'($signed(p[RotProdW-1:RotShift]));
    endfunction

    function automatic cdiff_t crs_term(input cprod_t p);
        return CrsDiffW'($signed(p[CrsProdW-1:CrsShift]));
    endfunction

endpackage

FILE: hdl/rtau_pipe_ctl.sv
`include "rigid_transform_adjoint_unit_core_defines.svh"

module rtau_pipe_ctl
    import rtau_pkg::*;
#(
    parameter int Depth = FrontDepth
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [Depth-1:0] load
);

    logic [Depth-1:0] valid_reg;
    logic [Depth-1:0] valid_next;
    logic [Depth-1:0] ready;

    // Ready chain: a stage takes data when empty or when its successor moves
    always_comb
    begin
        ready[Depth-1] = !valid_reg[Depth-1] || !out_stall;
        for (int k = Depth - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    // Valid bits travel with the data
    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < Depth; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load      = ready;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[Depth-1];

    // Back-pressure only when every stage is occupied
    `RTAU_ASSERT_IMPL(a_stall_full, in_stall, &valid_reg)
    // An open output lets a request in
    `RTAU_ASSERT_IMPL(a_free_flow, !out_stall, !in_stall)
    // An accepted request lands in the first stage
    `RTAU_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, valid_reg[0])
    // Nothing leaves while the output is stalled
    `RTAU_ASSERT_NEXT(a_no_loss, out_stall, $countones(valid_reg) >= $past($countones(valid_reg)))

endmodule

FILE: hdl/rtau_cfg.sv
module rtau_cfg
    import rtau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    output pose_t              pose
);

    logic [2:0][CfgW-1:0] row_reg;
    logic [2:0][CfgW-1:0] row_next;
    word_t [2:0]          trans_reg;
    word_t [2:0]          trans_next;

    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        row_next   = row_reg;
        trans_next = trans_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROT_ROW0: row_next[0]   = cfg_data;
                REG_ROT_ROW1: row_next[1]   = cfg_data;
                REG_ROT_ROW2: row_next[2]   = cfg_data;
                REG_TRANS_X:  trans_next[0] = cfg_data[WordW-1:0];
                REG_TRANS_Y:  trans_next[1] = cfg_data[WordW-1:0];
                REG_TRANS_Z:  trans_next[2] = cfg_data[WordW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= {RotRow2Rst, RotRow1Rst, RotRow0Rst};
            trans_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            trans_reg <= trans_next;
        end
    end

    // Unpack rows into entries, entry 0 in the low slot
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pose.rot[i][j] = row_reg[i][CoefW*j +: CoefW];
            end
        end
        pose.trans = trans_reg;
    end

endmodule

FILE: hdl/rtau_front.sv
module rtau_front
    import rtau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  pose_t pose,
    input  logic  in_valid,
    output logic  in_stall,
    input  req_t  in_data,
    output logic  out_valid,
    input  logic  out_stall,
    output mid_t  out_data
);

    logic [FrontDepth-1:0] load;

    // Stage 0: operand select
    func_t       func0_reg, func0_next;
    word_t [2:0] u0_reg, u0_next;
    word_t [2:0] xt0_reg, xt0_next;
    word_t [2:0] xb0_reg, xb0_next;
    word_t [2:0] dif0;

    // Stage 1: products
    func_t            func1_reg, func1_next;
    rprod_t [2:0][2:0] pa1_reg, pa1_next;
    rprod_t [2:0][2:0] pb1_reg, pb1_next;
    cprod_t [2:0][1:0] pc1_reg, pc1_next;
    word_t [2:0]      xb1_reg, xb1_next;

    // Stage 2: sums
    func_t        func2_reg, func2_next;
    rsum_t [2:0]  sa2_reg, sa2_next;
    rsum_t [2:0]  sb2_reg, sb2_next;
    cdiff_t [2:0] cc2_reg, cc2_next;
    word_t [2:0]  xb2_reg, xb2_next;

    // Stage 3: saturation, hand-off register
    mid_t mid3_reg, mid3_next;

    rtau_pipe_ctl #(
        .Depth (FrontDepth)
    ) u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .load      (load)
    );

    // Stage 0: x - t for the inverse point mode, pick the rotation operand
    always_comb
    begin
        func0_next = in_data.func;
        xt0_next   = {in_data.in_v2, in_data.in_v1, in_data.in_v0};
        xb0_next   = {in_data.in_v5, in_data.in_v4, in_data.in_v3};
        for (int i = 0; i < 3; i++)
        begin
            dif0[i] = sat_word(WideW'($signed(xt0_next[i])) - WideW'($signed(pose.trans[i])));
        end
        case (in_data.func)
            FUNC_POINT:     u0_next = xt0_next;
            FUNC_POINT_INV: u0_next = dif0;
            FUNC_ADJ:       u0_next = xb0_next;
            FUNC_ADJ_T:     u0_next = xt0_next;
            default:        u0_next = xt0_next;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            func0_reg <= func0_next;
            u0_reg    <= u0_next;
            xt0_reg   <= xt0_next;
            xb0_reg   <= xb0_next;
        end
    end

    // Stage 1: first rotation, R*x_top for the adjoint, t x x_top
    always_comb
    begin
        logic  tr;
        coef_t m;
        tr = (func0_reg == FUNC_POINT_INV) || (func0_reg == FUNC_ADJ_T);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m = tr ? pose.rot[j][i] : pose.rot[i][j];
                pa1_next[i][j] = rot_mul(m, u0_reg[j]);
                pb1_next[i][j] = rot_mul(pose.rot[i][j], xt0_reg[j]);
            end
        end
        pc1_next[0][0] = crs_mul(pose.trans[1], xt0_reg[2]);
        pc1_next[0][1] = crs_mul(pose.trans[2], xt0_reg[1]);
        pc1_next[1][0] = crs_mul(pose.trans[2], xt0_reg[0]);
        pc1_next[1][1] = crs_mul(pose.trans[0], xt0_reg[2]);
        pc1_next[2][0] = crs_mul(pose.trans[0], xt0_reg[1]);
        pc1_next[2][1] = crs_mul(pose.trans[1], xt0_reg[0]);
        func1_next = func0_reg;
        xb1_next   = xb0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            func1_reg <= func1_next;
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
            pc1_reg   <= pc1_next;
            xb1_reg   <= xb1_next;
        end
    end

    // Stage 2: row sums, translation for the point mode, cross differences
    always_comb
    begin
        rsum_t tadd;
        for (int i = 0; i < 3; i++)
        begin
            tadd = (func1_reg == FUNC_POINT) ? RotSumW'($signed(pose.trans[i])) : rsum_t'(0);
            sa2_next[i] = rot_term(pa1_reg[i][0]) + rot_term(pa1_reg[i][1])
                        + rot_term(pa1_reg[i][2]) + tadd;
            sb2_next[i] = rot_term(pb1_reg[i][0]) + rot_term(pb1_reg[i][1])
                        + rot_term(pb1_reg[i][2]);
            cc2_next[i] = crs_term(pc1_reg[i][0]) - crs_term(pc1_reg[i][1]);
        end
        func2_next = func1_reg;
        xb2_next   = xb1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            func2_reg <= func2_next;
            sa2_reg   <= sa2_next;
            sb2_reg   <= sb2_next;
            cc2_reg   <= cc2_next;
            xb2_reg   <= xb2_next;
        end
    end

    // Stage 3: clamp first rotation and x_bot - t x x_top
    always_comb
    begin
        mid3_next.func = func2_reg;
        for (int i = 0; i < 3; i++)
        begin
            mid3_next.ra[i] = sat_word(WideW'($signed(sa2_reg[i])));
            mid3_next.bv[i] = sat_word(WideW'($signed(xb2_reg[i]))
                                     - WideW'($signed(cc2_reg[i])));
        end
        mid3_next.sb = sb2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            mid3_reg <= mid3_next;
        end
    end

    assign out_data = mid3_reg;

endmodule

FILE: hdl/rtau_back.sv
module rtau_back
    import rtau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  pose_t pose,
    input  logic  in_valid,
    output logic  in_stall,
    input  mid_t  in_data,
    output logic  out_valid,
    input  logic  out_stall,
    output rsp_t  out_data
);

    logic [BackDepth-1:0] load;

    // Stage 4: products
    func_t             func4_reg, func4_next;
    word_t [2:0]       ra4_reg, ra4_next;
    rsum_t [2:0]       sb4_reg, sb4_next;
    cprod_t [2:0][1:0] pd4_reg, pd4_next;
    rprod_t [2:0][2:0] pe4_reg, pe4_next;

    // Stage 5: sums
    func_t        func5_reg, func5_next;
    word_t [2:0]  ra5_reg, ra5_next;
    rsum_t [2:0]  sb5_reg, sb5_next;
    cdiff_t [2:0] cd5_reg, cd5_next;
    rsum_t [2:0]  se5_reg, se5_next;

    // Stage 6: result register
    rsp_t rsp6_reg, rsp6_next;

    rtau_pipe_ctl #(
        .Depth (BackDepth)
    ) u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .load      (load)
    );

    // Stage 4: t x R*x_bot for the adjoint, R^T*b for the transposed adjoint
    always_comb
    begin
        pd4_next[0][0] = crs_mul(pose.trans[1], in_data.ra[2]);
        pd4_next[0][1] = crs_mul(pose.trans[2], in_data.ra[1]);
        pd4_next[1][0] = crs_mul(pose.trans[2], in_data.ra[0]);
        pd4_next[1][1] = crs_mul(pose.trans[0], in_data.ra[2]);
        pd4_next[2][0] = crs_mul(pose.trans[0], in_data.ra[1]);
        pd4_next[2][1] = crs_mul(pose.trans[1], in_data.ra[0]);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pe4_next[i][j] = rot_mul(pose.rot[j][i], in_data.bv[j]);
            end
        end
        func4_next = in_data.func;
        ra4_next   = in_data.ra;
        sb4_next   = in_data.sb;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            func4_reg <= func4_next;
            ra4_reg   <= ra4_next;
            sb4_reg   <= sb4_next;
            pd4_reg   <= pd4_next;
            pe4_reg   <= pe4_next;
        end
    end

    // Stage 5: cross differences and second rotation sums
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cd5_next[i] = crs_term(pd4_reg[i][0]) - crs_term(pd4_reg[i][1]);
            se5_next[i] = rot_term(pe4_reg[i][0]) + rot_term(pe4_reg[i][1])
                        + rot_term(pe4_reg[i][2]);
        end
        func5_next = func4_reg;
        ra5_next   = ra4_reg;
        sb5_next   = sb4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            func5_reg <= func5_next;
            ra5_reg   <= ra5_next;
            sb5_reg   <= sb5_next;
            cd5_reg   <= cd5_next;
            se5_reg   <= se5_next;
        end
    end

    // Stage 6: final add and clamp, assemble the result per mode
    always_comb
    begin
        word_t [2:0] top;
        word_t [2:0] bot;
        word_t [2:0] adj_top;
        word_t [2:0] adjt_bot;
        for (int i = 0; i < 3; i++)
        begin
            adj_top[i]  = sat_word(WideW'($signed(sb5_reg[i])) + WideW'($signed(cd5_reg[i])));
            adjt_bot[i] = sat_word(WideW'($signed(se5_reg[i])));
        end
        case (func5_reg)
            FUNC_POINT,
            FUNC_POINT_INV:
            begin
                top = ra5_reg;
                bot = '0;
            end
            FUNC_ADJ:
            begin
                top = adj_top;
                bot = ra5_reg;
            end
            FUNC_ADJ_T:
            begin
                top = ra5_reg;
                bot = adjt_bot;
            end
            default:
            begin
                top = ra5_reg;
                bot = '0;
            end
        endcase
        rsp6_next.out_v0 = top[0];
        rsp6_next.out_v1 = top[1];
        rsp6_next.out_v2 = top[2];
        rsp6_next.out_v3 = bot[0];
        rsp6_next.out_v4 = bot[1];
        rsp6_next.out_v5 = bot[2];
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            rsp6_reg <= rsp6_next;
        end
    end

    assign out_data = rsp6_reg;

endmodule

FILE: hdl/rigid_transform_adjoint_unit_core.sv
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   req_t: func, in_v0..in_v5
// rsp      out  rsp_valid/rsp_stall   rsp_t: out_v0..out_v5
// cfg      in   cfg_valid/cfg_ready   cfg_index (3 bits), cfg_data (48 bits)
//
// One request per cycle sustained while rsp_stall is low; rsp_valid rises when the
// request reaches the last of seven register stages (four front, three back),
// the first one loaded at the accepting edge.
// rst_n (async) clears all stage valid bits and loads identity R, zero t.
// A stalled result holds only the full stages; bubbles upstream keep filling.
// cfg_ready is always high; writes to indexes past trans_z are dropped.
module rigid_transform_adjoint_unit_core
    import rtau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data
);

    pose_t pose;
    mid_t  mid_data;
    logic  mid_valid;
    logic  mid_stall;

    // Pose registers
    rtau_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pose      (pose)
    );

    // First rotation, cross with x_top, clamps
    rtau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .in_data   (req_data),
        .out_valid (mid_valid),
        .out_stall (mid_stall),
        .out_data  (mid_data)
    );

    // Second rotation or cross with bottom, final assembly
    rtau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .in_valid  (mid_valid),
        .in_stall  (mid_stall),
        .in_data   (mid_data),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp_data)
    );

endmodule
